### src/srw_pkg.sv
`default_nettype none
package srw_pkg;

  localparam int MAX_WINDOW_DEF = 16;
  localparam int FRAME_BITS_DEF = 16;

  localparam int TOTAL_W  = 16;
  localparam int WSIZE_W  = 5;
  localparam int BASE_W   = 17;
  localparam int MASK_W   = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;

  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 16'd10;
  localparam logic [WSIZE_W-1:0] WSIZE_RESET = 5'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_FRAMES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SLIDE,
    ST_EMIT
  } state_t;

  // one-hot (or all-zero) control for the slot chain
  typedef struct packed {
    logic load;
    logic slide;
    logic emit;
  } cell_ctrl_t;

endpackage
`default_nettype wire

### src/srw_cell.sv
`default_nettype none
module srw_cell import srw_pkg::*; #(
  parameter int IDX   = 0,
  parameter int WIN_W = 5
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cell_ctrl_t         ctrl,
  input  wire logic [BASE_W-1:0]  base,
  input  wire logic [TOTAL_W-1:0] total,
  input  wire logic [WIN_W-1:0]   win,
  input  wire logic               drop,
  input  wire logic               acked_in,
  input  wire logic               sent_in,
  input  wire logic               ok_in,
  output logic                    acked,
  output logic                    sent,
  output logic                    ok
);

  logic acked_r, acked_nxt;
  logic sent_r, sent_nxt;
  logic ok_r, ok_nxt;
  logic in_range;

  // slot lies inside the window and its frame is not past the total
  assign in_range = (32'(win) > IDX) &&
                    (({1'b0, base} + (BASE_W+1)'(IDX)) <= (BASE_W+1)'(total));

  always_comb begin
    acked_nxt = acked_r;
    sent_nxt  = sent_r;
    ok_nxt    = ok_r;
    priority if (ctrl.load) begin
      sent_nxt  = in_range && !acked_r;
      ok_nxt    = !drop;
      acked_nxt = acked_r || (in_range && !drop);
    end else if (ctrl.slide) begin
      acked_nxt = acked_in;
    end else if (ctrl.emit) begin
      sent_nxt = sent_in;
      ok_nxt   = ok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acked_r <= 1'b0;
      sent_r  <= 1'b0;
    end else begin
      acked_r <= acked_nxt;
      sent_r  <= sent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ok_r <= ok_nxt;
  end

  assign acked = acked_r;
  assign sent  = sent_r;
  assign ok    = ok_r;

endmodule
`default_nettype wire

### src/selective_repeat_window_core.sv
// Selective-repeat sender window.
// Configuration: cfg_we/cfg_index/cfg_wdata write total_frames (index 0) or
// window_size (index 1); write only while busy is low.
// Input: a round is taken when start is high and busy is low; in_drop_mask
// marks the window slots whose frames are lost in that round.
// Output: one result per frame sent, each shown for one cycle with out_valid;
// out_last marks the final result of the round. When every frame is already
// acknowledged, the round gives a single result with out_all_done set.
// Sequence: the round loads all slot cells in the accept cycle, then the base
// slides one slot per cycle, then the result chain shifts one slot per cycle
// toward slot 0, ending after the highest sent slot. The done result appears
// in the cycle after start.
// Results are registered and leave in the cycle after they are formed; the
// receiver cannot stall, so nothing waits on it.
// Reset: window base 1, no slot acknowledged, total_frames 10, window_size 3.
`default_nettype none
module selective_repeat_window_core import srw_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [MASK_W-1:0]    in_drop_mask,
  output logic                      out_valid,
  output logic [15:0]               out_frame_number,
  output logic                      out_delivered,
  output logic [BASE_W-1:0]         out_new_base,
  output logic                      out_all_done,
  output logic                      out_last
);

  localparam int WIN_W = $clog2(MAX_WINDOW + 1);
  localparam logic [BASE_W-1:0] FRAME_MASK = (FRAME_BITS >= BASE_W) ? {BASE_W{1'b1}} :
                                             BASE_W'((64'(1) << FRAME_BITS) - 64'(1));

  state_t state_r, state_nxt;
  logic [BASE_W-1:0]  base_r, base_nxt;
  logic [BASE_W-1:0]  frm_r, frm_nxt;
  logic [TOTAL_W-1:0] total_r;
  logic [WSIZE_W-1:0] wsize_r;
  logic [WIN_W-1:0]   win;
  cell_ctrl_t         ctrl;

  logic              ov_r, ov_nxt;
  logic [15:0]       ofn_r, ofn_nxt;
  logic              odl_r, odl_nxt;
  logic [BASE_W-1:0] onb_r, onb_nxt;
  logic              oad_r, oad_nxt;
  logic              olst_r, olst_nxt;

  logic [MAX_WINDOW-1:0] acked, sent, ok;
  logic                  rest_sent;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= TOTAL_RESET;
      wsize_r <= WSIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TOTAL_FRAMES: total_r <= cfg_wdata[TOTAL_W-1:0];
        CFG_WINDOW_SIZE:  wsize_r <= cfg_wdata[WSIZE_W-1:0];
        default:          total_r <= total_r;
      endcase
    end
  end

  // zero window acts as one slot, oversized as the full chain
  always_comb begin
    priority if (wsize_r == '0) begin
      win = WIN_W'(1);
    end else if (32'(wsize_r) > MAX_WINDOW) begin
      win = WIN_W'(MAX_WINDOW);
    end else begin
      win = WIN_W'(wsize_r);
    end
  end

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic drop_i;
    logic acked_up, sent_up, ok_up;

    if (i < MASK_W) begin : g_mask
      assign drop_i = in_drop_mask[i];
    end else begin : g_nomask
      assign drop_i = 1'b0;
    end

    if (i + 1 < MAX_WINDOW) begin : g_up
      assign acked_up = acked[i+1];
      assign sent_up  = sent[i+1];
      assign ok_up    = ok[i+1];
    end else begin : g_end
      assign acked_up = 1'b0;
      assign sent_up  = 1'b0;
      assign ok_up    = 1'b0;
    end

    srw_cell #(
      .IDX   (i),
      .WIN_W (WIN_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .base     (base_r),
      .total    (total_r),
      .win      (win),
      .drop     (drop_i),
      .acked_in (acked_up),
      .sent_in  (sent_up),
      .ok_in    (ok_up),
      .acked    (acked[i]),
      .sent     (sent[i]),
      .ok       (ok[i])
    );
  end

  assign rest_sent = |(sent >> 1);

  always_comb begin
    state_nxt = state_r;
    base_nxt  = base_r;
    frm_nxt   = frm_r;
    ctrl      = '0;
    ov_nxt    = 1'b0;
    ofn_nxt   = ofn_r;
    odl_nxt   = odl_r;
    onb_nxt   = onb_r;
    oad_nxt   = oad_r;
    olst_nxt  = olst_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (base_r > BASE_W'(total_r)) begin
            ov_nxt   = 1'b1;
            ofn_nxt  = '0;
            odl_nxt  = 1'b0;
            onb_nxt  = base_r;
            oad_nxt  = 1'b1;
            olst_nxt = 1'b1;
          end else begin
            ctrl.load = 1'b1;
            frm_nxt   = base_r;
            state_nxt = ST_SLIDE;
          end
        end
      end
      ST_SLIDE: begin
        if (base_r <= BASE_W'(total_r) && acked[0]) begin
          ctrl.slide = 1'b1;
          base_nxt   = base_r + BASE_W'(1);
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (|sent) begin
          ctrl.emit = 1'b1;
          frm_nxt   = frm_r + BASE_W'(1);
          if (sent[0]) begin
            ov_nxt   = 1'b1;
            ofn_nxt  = 16'(frm_r & FRAME_MASK);
            odl_nxt  = ok[0];
            onb_nxt  = base_r;
            oad_nxt  = 1'b0;
            olst_nxt = !rest_sent;
            if (!rest_sent) begin
              state_nxt = ST_IDLE;
            end
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      base_r  <= BASE_W'(1);
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      base_r  <= base_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frm_r  <= frm_nxt;
    ofn_r  <= ofn_nxt;
    odl_r  <= odl_nxt;
    onb_r  <= onb_nxt;
    oad_r  <= oad_nxt;
    olst_r <= olst_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = ov_r;
  assign out_frame_number = ofn_r;
  assign out_delivered    = odl_r;
  assign out_new_base     = onb_r;
  assign out_all_done     = oad_r;
  assign out_last         = olst_r;

`ifndef ASSERT_OFF
  // an idle block holds no pending transfer in the result chain
  a_idle_chain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> (sent == '0))
    else $error("pending results left in slot chain while idle");

  // the base only moves forward while sliding
  a_slide_forward: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SLIDE) |=> (base_r >= $past(base_r)))
    else $error("window base moved backward during slide");

  // a done result is always the last of its round
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_all_done) |-> (out_last && !out_delivered))
    else $error("done result without last flag");
`endif

endmodule
`default_nettype wire
